// ----- rtl/core/tccw_pkg.sv -----
// Package for the text console cell writer: screen geometry, operation and
// character codes, register indexes, the sequencer state type and helpers.
// No dependencies.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int CELL_W = 16;

    // Operation codes carried in tuser
    localparam logic [2:0] FUNC_PUT   = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_SET   = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Control characters handled by put char
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_BS  = 8'h08;

    // Configuration register indexes
    localparam logic [1:0] REG_TEXT_ATTR  = 2'd0;
    localparam logic [1:0] REG_ERASE_ATTR = 2'd1;
    localparam logic [1:0] REG_BLANK_CODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_SCROLL,
        ST_BOTTOM,
        ST_RESP
    } tccw_state_t;

    // Linear cell address of a screen position
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    // True where a column is a multiple of the tab stop
    function automatic logic tab_multiple(input logic [COL_W:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= COLUMNS / TAB_STOP; k++) begin
            if (c == (COL_W + 1)'(k * TAB_STOP)) begin
                hit = 1'b1;
            end
        end
        tab_multiple = hit;
    endfunction

endpackage

// ----- rtl/core/tccw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/text_console_cell_writer.sv -----
// Text console cell writer: a sequencer over one screen RAM port pair; uses tccw_pkg, tccw_ram.
// Most operations go through decode to the response state; a read cell adds a read state,
// newline and tab add a fill sweep, a scroll adds a copy and a bottom-row sweep, and
// clear screen sweeps every cell; a result still held by the sink stalls the response.
// One item at a time: s_tready returns the cycle after the result loads.
// Reset: cursor at the origin, registers to defaults; screen cells stay unwritten.
module text_console_cell_writer (
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // char_code[7:0], column[14:8], row[19:15], cell_attr[27:20]
    input  logic [2:0]  s_tuser,  // func[2:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // cursor_column[6:0], cursor_row[11:7],
                                  // cursor_offset[22:12], read_code[30:23], read_attr[38:31]
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W  = tccw_pkg::COL_W;
    localparam int ROW_W  = tccw_pkg::ROW_W;
    localparam int ADDR_W = tccw_pkg::ADDR_W;
    localparam int CNT_W  = tccw_pkg::CNT_W;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(tccw_pkg::COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(tccw_pkg::ROWS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tccw_pkg::tccw_state_t state_reg, state_next;

    logic [2:0]             func_reg;
    logic [7:0]             code_reg;
    logic [6:0]             col_reg;
    logic [4:0]             row_reg;
    logic [7:0]             attr_reg;

    logic [COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [15:0]            got_reg, got_next;
    logic [39:0]            out_tdata_reg, out_tdata_next;
    logic                   out_valid_reg, out_valid_next;

    logic [7:0]             text_attr_reg, erase_attr_reg, blank_code_reg;

    // RAM port controls
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [tccw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    // ------------------------------------------------------------------
    // Shared position logic
    // ------------------------------------------------------------------
    logic [COL_W:0]         col_inc;
    logic                   at_line_end;
    logic                   at_bottom;
    logic                   in_range;
    logic                   fill_done;
    logic                   out_load;
    logic [ADDR_W-1:0]      cur_addr;
    logic [ADDR_W-1:0]      item_addr;
    logic [COL_W-1:0]       bs_col;
    logic [ROW_W-1:0]       bs_row;
    logic                   cfg_write;

    assign col_inc     = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
    assign at_line_end = (col_inc == (COL_W + 1)'(tccw_pkg::COLUMNS));
    assign at_bottom   = (cur_row_reg == ROW_LAST);
    assign in_range    = ({1'b0, col_reg} < 8'(tccw_pkg::COLUMNS))
                      && ({3'b0, row_reg} < 8'(tccw_pkg::ROWS));
    // Tab stops at the next multiple of the tab width; newline runs to the line end
    assign fill_done   = at_line_end
                      || ((code_reg == tccw_pkg::CHAR_TAB) && tccw_pkg::tab_multiple(col_inc));
    assign cur_addr    = tccw_pkg::cell_addr(cur_row_reg, cur_col_reg);
    assign item_addr   = tccw_pkg::cell_addr(ROW_W'(row_reg), COL_W'(col_reg));
    assign out_load    = !out_valid_reg || m_tready;

    // Backspace target: wrap to the last column of the previous row from column zero
    assign bs_col = (cur_col_reg == '0) ? COL_LAST : cur_col_reg - COL_W'(1);
    assign bs_row = (cur_col_reg == '0) ? cur_row_reg - ROW_W'(1) : cur_row_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tccw_pkg::ST_DECODE;
                end
            end
            tccw_pkg::ST_DECODE:
            begin
                unique case (func_reg)
                    tccw_pkg::FUNC_PUT:
                    begin
                        case (code_reg)
                            tccw_pkg::CHAR_CR, tccw_pkg::CHAR_BS:
                                state_next = tccw_pkg::ST_RESP;
                            tccw_pkg::CHAR_LF, tccw_pkg::CHAR_TAB:
                                state_next = tccw_pkg::ST_FILL;
                            default:
                                state_next = (at_line_end && at_bottom) ? tccw_pkg::ST_SCROLL
                                                                       : tccw_pkg::ST_RESP;
                        endcase
                    end
                    tccw_pkg::FUNC_CLEAR:
                        state_next = tccw_pkg::ST_CLEAR;
                    tccw_pkg::FUNC_READ:
                        state_next = in_range ? tccw_pkg::ST_READ : tccw_pkg::ST_RESP;
                    default:
                        state_next = tccw_pkg::ST_RESP;
                endcase
            end
            tccw_pkg::ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = (at_line_end && at_bottom) ? tccw_pkg::ST_SCROLL
                                                           : tccw_pkg::ST_RESP;
                end
            end
            tccw_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(tccw_pkg::CELL_COUNT - 1))
                begin
                    state_next = tccw_pkg::ST_RESP;
                end
            end
            tccw_pkg::ST_READ:
                state_next = tccw_pkg::ST_RESP;
            tccw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == CNT_W'(tccw_pkg::CELL_COUNT))
                begin
                    state_next = tccw_pkg::ST_BOTTOM;
                end
            end
            tccw_pkg::ST_BOTTOM:
            begin
                if (cnt_reg == CNT_W'(tccw_pkg::CELL_COUNT - 1))
                begin
                    state_next = tccw_pkg::ST_RESP;
                end
            end
            tccw_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tccw_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM controls
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cnt_next       = cnt_reg;
        got_next       = got_reg;
        out_tdata_next = out_tdata_reg;
        // Drop the result once the sink takes it
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = {text_attr_reg, blank_code_reg};
        ram_re         = 1'b0;
        ram_raddr      = item_addr;

        unique case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
            end
            tccw_pkg::ST_DECODE:
            begin
                got_next = '0;
                // Scroll copy starts reading at the second row
                cnt_next = CNT_W'(tccw_pkg::COLUMNS);
                unique case (func_reg)
                    tccw_pkg::FUNC_PUT:
                    begin
                        case (code_reg)
                            tccw_pkg::CHAR_CR:
                                cur_col_next = '0;
                            tccw_pkg::CHAR_LF, tccw_pkg::CHAR_TAB:
                            begin
                            end
                            tccw_pkg::CHAR_BS:
                            begin
                                // Backspace at the origin does nothing
                                if (cur_col_reg != '0 || cur_row_reg != '0)
                                begin
                                    cur_col_next = bs_col;
                                    cur_row_next = bs_row;
                                    ram_we       = 1'b1;
                                    ram_waddr    = tccw_pkg::cell_addr(bs_row, bs_col);
                                    ram_wdata    = {erase_attr_reg, blank_code_reg};
                                end
                            end
                            default:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {text_attr_reg, code_reg};
                                if (at_line_end)
                                begin
                                    cur_col_next = '0;
                                    if (!at_bottom)
                                    begin
                                        cur_row_next = cur_row_reg + ROW_W'(1);
                                    end
                                end
                                else
                                begin
                                    cur_col_next = col_inc[COL_W-1:0];
                                end
                            end
                        endcase
                    end
                    tccw_pkg::FUNC_WRITE:
                    begin
                        ram_we    = in_range;
                        ram_waddr = item_addr;
                        ram_wdata = {attr_reg, code_reg};
                    end
                    tccw_pkg::FUNC_SET:
                    begin
                        cur_col_next = ({1'b0, col_reg} < 8'(tccw_pkg::COLUMNS))
                                     ? COL_W'(col_reg) : COL_LAST;
                        cur_row_next = ({3'b0, row_reg} < 8'(tccw_pkg::ROWS))
                                     ? ROW_W'(row_reg) : ROW_LAST;
                    end
                    tccw_pkg::FUNC_CLEAR:
                        cnt_next = '0;
                    tccw_pkg::FUNC_READ:
                        ram_re = in_range;
                    default:
                    begin
                    end
                endcase
            end
            tccw_pkg::ST_FILL:
            begin
                ram_we = 1'b1;
                if (at_line_end)
                begin
                    cur_col_next = '0;
                    if (!at_bottom)
                    begin
                        cur_row_next = cur_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    cur_col_next = col_inc[COL_W-1:0];
                end
            end
            tccw_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cnt_reg);
                ram_wdata = {attr_reg, blank_code_reg};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            tccw_pkg::ST_READ:
                got_next = ram_rdata;
            tccw_pkg::ST_SCROLL:
            begin
                // Read one row ahead and write the previous read one row up
                ram_re    = (cnt_reg < CNT_W'(tccw_pkg::CELL_COUNT));
                ram_raddr = ADDR_W'(cnt_reg);
                ram_we    = (cnt_reg > CNT_W'(tccw_pkg::COLUMNS));
                ram_waddr = ADDR_W'(cnt_reg - CNT_W'(tccw_pkg::COLUMNS + 1));
                ram_wdata = ram_rdata;
                if (cnt_reg == CNT_W'(tccw_pkg::CELL_COUNT))
                begin
                    cnt_next = CNT_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            tccw_pkg::ST_BOTTOM:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cnt_reg);
                ram_wdata = {erase_attr_reg, blank_code_reg};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            tccw_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    out_tdata_next = {1'b0, got_reg[15:8], got_reg[7:0], 11'(cur_addr),
                                      5'(cur_row_reg), 7'(cur_col_reg)};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tccw_pkg::ST_IDLE;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
            text_attr_reg  <= 8'd7;
            erase_attr_reg <= 8'd7;
            blank_code_reg <= 8'd32;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (paddr[3:2])
                    tccw_pkg::REG_TEXT_ATTR:  text_attr_reg  <= pwdata[7:0];
                    tccw_pkg::REG_ERASE_ATTR: erase_attr_reg <= pwdata[7:0];
                    tccw_pkg::REG_BLANK_CODE: blank_code_reg <= pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload: item fields, sweep counter, read data, result word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            code_reg <= s_tdata[7:0];
            col_reg  <= s_tdata[14:8];
            row_reg  <= s_tdata[19:15];
            attr_reg <= s_tdata[27:20];
        end
        cnt_reg       <= cnt_next;
        got_reg       <= got_next;
        out_tdata_reg <= out_tdata_next;
    end

    // ------------------------------------------------------------------
    // Screen RAM
    // ------------------------------------------------------------------
    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (tccw_pkg::CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == tccw_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign pready   = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            tccw_pkg::REG_TEXT_ATTR:  prdata = {24'b0, text_attr_reg};
            tccw_pkg::REG_ERASE_ATTR: prdata = {24'b0, erase_attr_reg};
            tccw_pkg::REG_BLANK_CODE: prdata = {24'b0, blank_code_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cur_col_reg} < (COL_W + 1)'(tccw_pkg::COLUMNS))
        && ({1'b0, cur_row_reg} < (ROW_W + 1)'(tccw_pkg::ROWS)))
        else $error("cursor left the screen");

    a_write_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (ADDR_W + 1)'(tccw_pkg::CELL_COUNT)))
        else $error("screen write outside the cell range");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == tccw_pkg::ST_DECODE))
        else $error("accepted item not decoded");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tccw_pkg::ST_RESP && out_load) |=> (m_tvalid && s_tready))
        else $error("result not presented after response");

endmodule
